### rtl/core/opd_pkg.sv
package opd_pkg;

  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [15:0] OP_BCAST = 16'd9;

  localparam logic [15:0] POS_MAX = 16'hffff;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_BCAST = 2'd3;

  localparam logic [7:0] TERMINATOR = 8'h00;

  typedef struct packed {
    logic        valid;
    logic [1:0]  packet_kind;
    logic [15:0] header_number;
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic        last;
  } opd_result_t;

endpackage

### rtl/core/opd_parser.sv
module opd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [7:0]          rx_byte,
  output opd_pkg::opd_result_t res
);
  import opd_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] opcode_r, opcode_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [15:0] size_r, size_nxt;
  logic [15:0] number_r, number_nxt;
  logic [15:0] pos_inc;
  logic [15:0] word;
  logic [15:0] size_dec;

  assign pos_inc  = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;
  assign word     = {high_r, rx_byte};
  assign size_dec = size_r - 16'd1;

  always_comb begin
    pos_nxt    = pos_inc;
    opcode_nxt = opcode_r;
    high_nxt   = high_r;
    size_nxt   = size_r;
    number_nxt = number_r;
    res        = '0;
    if (pos_inc == 16'd1) begin
      high_nxt = rx_byte;
    end else if (pos_inc == 16'd2) begin
      opcode_nxt = word;
    end else begin
      case (opcode_r)
        OP_ACK: begin
          if (pos_inc == 16'd3) begin
            high_nxt = rx_byte;
          end else if (pos_inc == 16'd4) begin
            res.valid         = 1'b1;
            res.packet_kind   = KIND_ACK;
            res.header_number = word;
            res.last          = 1'b1;
          end
        end
        OP_DATA: begin
          if (pos_inc == 16'd3 || pos_inc == 16'd5) begin
            high_nxt = rx_byte;
          end else if (pos_inc == 16'd4) begin
            size_nxt = word;
          end else if (pos_inc == 16'd6) begin
            number_nxt = word;
            if (size_r == 16'd0) begin
              res.valid         = 1'b1;
              res.packet_kind   = KIND_DATA;
              res.header_number = word;
              res.last          = 1'b1;
            end
          end else begin
            size_nxt          = size_dec;
            res.valid         = 1'b1;
            res.packet_kind   = KIND_DATA;
            res.header_number = number_r;
            res.payload_byte  = rx_byte;
            res.has_byte      = 1'b1;
            res.last          = (size_dec == 16'd0);
          end
        end
        OP_ERROR: begin
          if (pos_inc == 16'd3) begin
            high_nxt = rx_byte;
          end else if (pos_inc == 16'd4) begin
            number_nxt = word;
          end else begin
            res.valid         = 1'b1;
            res.packet_kind   = KIND_ERROR;
            res.header_number = number_r;
            res.payload_byte  = rx_byte;
            res.has_byte      = (rx_byte != TERMINATOR);
            res.last          = (rx_byte == TERMINATOR);
          end
        end
        OP_BCAST: begin
          if (pos_inc == 16'd3) begin
            number_nxt = {8'd0, rx_byte};
          end else begin
            res.valid         = 1'b1;
            res.packet_kind   = KIND_BCAST;
            res.header_number = number_r;
            res.payload_byte  = rx_byte;
            res.has_byte      = (rx_byte != TERMINATOR);
            res.last          = (rx_byte == TERMINATOR);
          end
        end
        default: begin
        end
      endcase
    end
    if (res.last) begin
      pos_nxt    = '0;
      opcode_nxt = '0;
      high_nxt   = '0;
      size_nxt   = '0;
      number_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      opcode_r <= '0;
      high_r   <= '0;
      size_r   <= '0;
      number_r <= '0;
    end else if (en) begin
      pos_r    <= pos_nxt;
      opcode_r <= opcode_nxt;
      high_r   <= high_nxt;
      size_r   <= size_nxt;
      number_r <= number_nxt;
    end
  end

  // A completed packet leaves the parser ready for a fresh opcode.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.valid && res.last |=> pos_r == 16'd0 && opcode_r == 16'd0)
    else $error("parser state not cleared after packet end");

  a_known_op: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> opcode_r == OP_ACK || opcode_r == OP_DATA ||
                  opcode_r == OP_ERROR || opcode_r == OP_BCAST)
    else $error("result raised for an unknown opcode");

  a_no_header_result: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> pos_r >= 16'd3)
    else $error("result raised inside the opcode");

endmodule

### rtl/core/opcode_packet_deframer.sv
// A result shows on the out_ ports in the cycle after the transfer of its byte
// when the output register is free; header and swallowed bytes give none.
// Throughput: one byte per cycle, held back only when the output register and
// its skid stage are both full.
// Reset: synchronous and active low; it clears the parse state and empties both
// output stages.
module opcode_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_packet_kind,
  output logic [15:0] out_header_number,
  output logic [7:0]  out_payload_byte,
  output logic        out_has_byte,
  output logic        out_last
);
  import opd_pkg::*;

  opd_result_t res;
  opd_result_t out_r;
  opd_result_t skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic        take;
  logic        out_free;

  assign in_stall = skid_valid_r;
  assign take     = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  opd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (take),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_r       <= res;
        out_valid_r <= take && res.valid;
      end
    end else if (take && res.valid) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_kind   = out_r.packet_kind;
  assign out_header_number = out_r.header_number;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_has_byte      = out_r.has_byte;
  assign out_last          = out_r.last;

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register is empty");

  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && take && res.valid |=> skid_valid_r)
    else $error("result lost while output was stalled");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid stage did not move to the output register");

endmodule
